// File: sv/mtg_pkg.sv
// Shared constants, codes and types of the Mersenne Twister word generator.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package mtg_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned POS_W         = $clog2(STATE_WORDS);
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(STATE_WORDS - 1);
  localparam logic [WORD_W-1:0] SEED_MULT = 32'd69069;

  // Reset values of the configuration registers.
  localparam logic [WORD_W-1:0] TWIST_MATRIX_RST  = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TEMPER_MASK_B_RST = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_MASK_C_RST = 32'hefc60000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TWIST_MATRIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPER_MASK_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPER_MASK_C = 2'd2;

  typedef enum logic {
    OP_RESEED = 1'b0,
    OP_DRAW   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SEED_DONE,
    ST_RD_NXT,
    ST_RD_MID,
    ST_TWIST
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_seed;
    logic fill_we;
    logic rd_nxt;
    logic rd_mid;
    logic twist_wr;
    logic seed_done;
  } mtg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;
    logic out_free;
  } mtg_sts_t;

endpackage

`default_nettype wire

// File: sv/mtg_ifs.sv
// Valid/ready channel interfaces of the generator: input items and result words.
// Depends on nothing but the widths of the work items.
`default_nettype none

interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  opcode;
  logic [31:0] seed_value;

  modport source(output valid, output opcode, output seed_value, input ready);
  modport sink(input valid, input opcode, input seed_value, output ready);
endinterface

interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_value;

  modport source(output valid, output random_value, input ready);
  modport sink(input valid, input random_value, output ready);
endinterface

`default_nettype wire

// File: sv/mtg_ctrl.sv
// Controller of the generator: sequences reseed fills and draw twists.
// Depends on mtg_pkg for the state enum and the command and status structs.
`default_nettype none

module mtg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_opcode,
  output logic                  in_ready,
  input  wire mtg_pkg::mtg_sts_t sts,
  output mtg_pkg::mtg_cmd_t     cmd
);
  import mtg_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_opcode == OP_DRAW) ? ST_RD_NXT : ST_FILL;
        end
      end
      ST_FILL: begin
        if (sts.fill_last) state_nxt = ST_SEED_DONE;
      end
      ST_SEED_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_RD_NXT: state_nxt = ST_RD_MID;
      ST_RD_MID: state_nxt = ST_TWIST;
      ST_TWIST: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    cmd            = '0;
    cmd.start_seed = (state_r == ST_IDLE) && in_valid && (in_opcode == OP_RESEED);
    cmd.fill_we    = (state_r == ST_FILL);
    cmd.rd_nxt     = (state_r == ST_RD_NXT);
    cmd.rd_mid     = (state_r == ST_RD_MID);
    cmd.twist_wr   = (state_r == ST_TWIST) && sts.out_free;
    cmd.seed_done  = (state_r == ST_SEED_DONE) && sts.out_free;
  end

endmodule

`default_nettype wire

// File: sv/mtg_datapath.sv
// Datapath of the generator: state store, seed multiplier, twist, tempering,
// configuration registers and the result register. Depends on mtg_pkg.
`default_nettype none

module mtg_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mtg_pkg::mtg_cmd_t             cmd,
  output mtg_pkg::mtg_sts_t                  sts,
  input  wire logic [31:0]                   in_seed_value,
  input  wire logic                          cfg_we,
  input  wire logic [mtg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [31:0]                        out_data
);
  import mtg_pkg::*;

  localparam logic [POS_W:0] MID_STEP  = (POS_W + 1)'(MIDDLE_OFFSET % STATE_WORDS);
  localparam logic [POS_W:0] WORDS_EXT = (POS_W + 1)'(STATE_WORDS);

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v,
                                               input logic [WORD_W-1:0] mask_b,
                                               input logic [WORD_W-1:0] mask_c);
    logic [WORD_W-1:0] t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & mask_b);
    t = t ^ ((t << 15) & mask_c);
    t = t ^ (t >> 18);
    return t;
  endfunction

  logic [WORD_W-1:0] twist_matrix_r;
  logic [WORD_W-1:0] temper_mask_b_r;
  logic [WORD_W-1:0] temper_mask_c_r;

  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  fill_cnt_r;
  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] cur_word_r;
  logic [WORD_W-1:0] nxt_word_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_data_r;

  logic [WORD_W-1:0] store [STATE_WORDS];

  logic [POS_W-1:0]  pos_nxt;
  logic [POS_W:0]    mid_sum;
  logic [POS_W-1:0]  mid_pos;
  logic [WORD_W-1:0] seed_nxt;
  logic [WORD_W-1:0] y_word;
  logic [WORD_W-1:0] twist_word;
  logic [POS_W-1:0]  mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [WORD_W-1:0] mem_wdata;

  assign pos_nxt  = (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
  assign mid_sum  = {1'b0, pos_r} + MID_STEP;
  assign mid_pos  = (mid_sum >= WORDS_EXT) ? POS_W'(mid_sum - WORDS_EXT) : mid_sum[POS_W-1:0];
  assign seed_nxt = WORD_W'(seed_r * SEED_MULT);

  // The store word at the current position is kept in cur_word_r, so a draw
  // reads only the following word and the middle word from the store.
  assign y_word     = {cur_word_r[WORD_W-1], nxt_word_r[WORD_W-2:0]};
  assign twist_word = rd_data_r ^ (y_word >> 1) ^ (y_word[0] ? twist_matrix_r : '0);

  always_comb begin
    mem_addr  = pos_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = twist_word;
    if (cmd.fill_we) begin
      mem_addr  = fill_cnt_r;
      mem_we    = 1'b1;
      mem_wdata = seed_r;
    end else if (cmd.rd_nxt) begin
      mem_addr = pos_nxt;
      mem_re   = 1'b1;
    end else if (cmd.rd_mid) begin
      mem_addr = mid_pos;
      mem_re   = 1'b1;
    end else if (cmd.twist_wr) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_r <= store[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      twist_matrix_r  <= TWIST_MATRIX_RST;
      temper_mask_b_r <= TEMPER_MASK_B_RST;
      temper_mask_c_r <= TEMPER_MASK_C_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TWIST_MATRIX:  twist_matrix_r  <= cfg_wdata;
        CFG_TEMPER_MASK_B: temper_mask_b_r <= cfg_wdata;
        CFG_TEMPER_MASK_C: temper_mask_c_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_seed) begin
        pos_r      <= '0;
        fill_cnt_r <= '0;
      end else if (cmd.fill_we) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
      end else if (cmd.twist_wr) begin
        pos_r <= pos_nxt;
      end
      if (cmd.twist_wr || cmd.seed_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_seed) begin
      seed_r     <= in_seed_value;
      cur_word_r <= in_seed_value;
    end else if (cmd.fill_we) begin
      seed_r <= seed_nxt;
    end
    if (cmd.rd_mid) nxt_word_r <= rd_data_r;
    if (cmd.twist_wr) begin
      cur_word_r <= nxt_word_r;
      out_data_r <= temper(twist_word, temper_mask_b_r, temper_mask_c_r);
    end else if (cmd.seed_done) begin
      out_data_r <= '0;
    end
  end

  assign sts.fill_last = (fill_cnt_r == LAST_POS);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

`default_nettype wire

// File: sv/mersenne_twister_generator_unit.sv
// Mersenne Twister word generator, top level: controller plus datapath.
// A draw steps through RD_NXT, RD_MID and TWIST, and no new item is taken before it
// ends. The single-port state store (two reads, one write) sets these steps.
// A reseed writes all 624 store words, one per cycle, and then returns a zero word.
// Reset clears the position and restores the configuration defaults; the state
// store is undefined until the first reseed.
`default_nettype none

module mersenne_twister_generator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mtg_in_if.sink                             in_ch,
  mtg_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [mtg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);
  import mtg_pkg::*;

  mtg_cmd_t cmd;
  mtg_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  logic [WORD_W-1:0] out_data;

  mtg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode[0]),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtg_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_seed_value (in_ch.seed_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_data)
  );

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.random_value = out_data;

endmodule

`default_nettype wire

// File: sv/mtg_checker.sv
// Port-level checker of the generator, bound to the top level.
// Depends on mtg_pkg for the opcode codes.
`default_nettype none

module mtg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [0:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_random_value
);
  import mtg_pkg::*;

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pending_r;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Items accepted whose result beat has not gone out yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_beat && !out_beat) begin
      pending_r <= pending_r + 1'b1;
    end else if (out_beat && !in_beat) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result shown with no item outstanding");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("more than two items outstanding");

  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_opcode[0] == OP_DRAW) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken again before a draw finished");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_value))
    else $error("stalled result beat changed");

endmodule

bind mersenne_twister_generator_unit mtg_checker u_mtg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_opcode        (in_ch.opcode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_random_value (out_ch.random_value)
);

`default_nettype wire
